>>> sv/gcls_pkg.sv
package gcls_pkg;

	localparam int AXES = 3;
	localparam int D_W = 17;
	localparam int PROD_W = 57;
	localparam int NORM_W = 19;
	localparam logic [NORM_W-1:0] NORM_MAX = 19'd524287;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_DIVISOR = 1'b1;

	localparam logic [1:0] PH_HIHAT = 2'd0;
	localparam logic [1:0] PH_CRASH = 2'd1;
	localparam logic [1:0] PH_CLASSIFY = 2'd2;

	localparam logic [1:0] GEST_NONE = 2'd0;
	localparam logic [1:0] GEST_HIHAT = 2'd1;
	localparam logic [1:0] GEST_CRASH = 2'd2;

	typedef struct packed {
		logic [31:0] threshold;
		logic [15:0] divisor;
	} cfg_t;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_MAG  = 12'b000000000010,
		ST_CMP  = 12'b000000000100,
		ST_DOT  = 12'b000000001000,
		ST_WGT  = 12'b000000010000,
		ST_SUM  = 12'b000000100000,
		ST_DIVS = 12'b000001000000,
		ST_DIVW = 12'b000010000000,
		ST_SQ   = 12'b000100000000,
		ST_NS   = 12'b001000000000,
		ST_NW   = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

endpackage

>>> sv/gcls_regs.sv
module gcls_regs
	import gcls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [31:0] thr_q;
	logic [15:0] div_q;

	assign pready = 1'b1;
	assign cfg.threshold = thr_q;
	assign cfg.divisor = div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 32'd3000000;
			div_q <= 16'd30000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_THRESHOLD: thr_q <= pwdata;
				REG_DIVISOR:   div_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = thr_q;
			REG_DIVISOR:   prdata = {16'd0, div_q};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

>>> sv/gcls_store.sv
module gcls_store #(
	parameter int AW = 7,
	parameter int DW = 51
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/gcls_div.sv
module gcls_div #(
	parameter int NW = 35,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	// Restoring division, one quotient bit per cycle shifted in behind the dividend.
	assign trial = {rem_q, num_q[NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = num_q;

endmodule

>>> sv/two_class_motion_gesture_classifier.sv
// Two-class motion gesture classifier. Each input word is an accelerometer sample
// (s_tuser 0) or a mode button release (s_tuser 1) and yields exactly one result word.
// For each sample one shared multiplier squares the three axes; strong classify
// samples also run six dot-product terms and two weightings on that multiplier.
// A release that ends a training phase walks the stored class entries, one memory
// read per cycle, then runs four serial divisions of 35 bits each on a shared
// divider. The class entries are kept in one synchronous memory of 2 x STORE_DEPTH
// words; it needs no clearing.
module two_class_motion_gesture_classifier
	import gcls_pkg::*;
#(
	parameter int STORE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // accel_x, accel_y, accel_z, pedal_open, zero fill
	input  logic [0:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // gesture, level, mode, zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int SW = D_W + CW + 1;
	localparam int DVW = (SW > 35) ? SW : 35;
	localparam int MW = AXES * D_W;

	cfg_t   cfg;
	state_t state_q;

	logic [1:0]                phase_q;
	logic signed [15:0]        off_q [AXES];
	logic [CW-1:0]             cnt_q [2];
	logic [IW-1:0]             ptr_q [2];
	logic signed [D_W-1:0]     cent_q [2*AXES];
	logic [NORM_W-1:0]         norm_q [2];

	logic signed [15:0]        a_q [AXES];
	logic signed [D_W-1:0]     d_q [AXES];
	logic                      pedal_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [PROD_W-1:0]  dc_q;
	logic signed [PROD_W-1:0]  wh_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [2:0]                step_q;
	logic [1:0]                comp_q;
	logic [CW-1:0]             rd_q;
	logic                      rvalid_s1;
	logic signed [SW-1:0]      sum_q [AXES];
	logic [1:0]                gest_q;
	logic                      lvl_q;
	logic [7:0]                out_q;
	logic                      out_valid_q;

	logic signed [36:0]        mul_a;
	logic signed [19:0]        mul_b;
	logic                      cls;
	logic [2:0]                cbase;
	logic [CW-1:0]             n_c;
	logic                      over_thr;
	logic                      mem_we;
	logic                      mem_re;
	logic [MW-1:0]             mem_rdata;
	logic                      div_start;
	logic [DVW-1:0]            div_num;
	logic [15:0]               div_den;
	logic                      div_done;
	logic [DVW-1:0]            div_q;
	logic signed [SW-1:0]      sum_sel;
	logic signed [D_W-1:0]     q17;
	logic signed [D_W-1:0]     avg;

	gcls_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	gcls_store #(.AW(IW + 1), .DW(MW)) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr({cls, ptr_q[cls]}),
		.wdata({d_q[2], d_q[1], d_q[0]}),
		.re(mem_re),
		.raddr({cls, rd_q[IW-1:0]}),
		.rdata(mem_rdata)
	);

	gcls_div #(.NW(DVW), .DW(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);

	assign cls = phase_q[0];
	assign cbase = cls ? 3'd3 : 3'd0;
	assign n_c = cnt_q[cls];
	assign over_thr = $unsigned(acc_q) > PROD_W'(cfg.threshold);
	assign mem_we = (state_q == ST_CMP) && over_thr &&
		(phase_q == PH_HIHAT || phase_q == PH_CRASH);
	assign mem_re = (state_q == ST_SUM) && (rd_q < n_c);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	assign sum_sel = sum_q[comp_q];
	assign div_start = (state_q == ST_DIVS) || (state_q == ST_NS);
	assign q17 = D_W'(div_q);
	assign avg = (n_c == '0) ? '0 : (sum_sel < 0 ? -q17 : q17);

	always_comb begin
		if (state_q == ST_DIVS) begin
			div_num = DVW'(sum_sel < 0 ? -sum_sel : sum_sel);
			div_den = 16'(n_c);
		end else begin
			div_num = DVW'(acc_q);
			div_den = (cfg.divisor == 16'd0) ? 16'd1 : cfg.divisor;
		end
	end

	// One shared multiplier; operands follow the sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MAG: begin
				if (step_q < 3'd3) begin
					mul_a = 37'(a_q[step_q[1:0]]);
					mul_b = 20'(a_q[step_q[1:0]]);
				end
			end
			ST_DOT: begin
				if (step_q < 3'd6) begin
					mul_a = 37'(d_q[(step_q < 3'd3) ? step_q[1:0] : 2'(step_q - 3'd3)]);
					mul_b = 20'(cent_q[step_q]);
				end
			end
			ST_WGT: begin
				if (step_q == 3'd0) begin
					mul_a = acc_q[36:0];
					mul_b = $signed({1'b0, norm_q[1]});
				end else begin
					mul_a = dc_q[36:0];
					mul_b = $signed({1'b0, norm_q[0]});
				end
			end
			ST_SQ: begin
				if (step_q < 3'd3) begin
					mul_a = 37'(cent_q[cbase + step_q]);
					mul_b = 20'(cent_q[cbase + step_q]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a * mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CLASSIFY;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				off_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				cnt_q[i] <= '0;
				ptr_q[i] <= '0;
				norm_q[i] <= '0;
			end
			for (int i = 0; i < 2 * AXES; i++) begin
				cent_q[i] <= '0;
			end
			step_q <= '0;
			comp_q <= '0;
			rd_q <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						for (int i = 0; i < AXES; i++) begin
							a_q[i] <= $signed(s_tdata[16*i +: 16]);
							d_q[i] <= D_W'($signed(s_tdata[16*i +: 16])) - D_W'(off_q[i]);
						end
						pedal_q <= s_tdata[48];
						gest_q <= GEST_NONE;
						lvl_q <= 1'b0;
						acc_q <= '0;
						step_q <= '0;
						if (!s_tuser[0]) begin
							state_q <= ST_MAG;
						end else if (phase_q == PH_HIHAT || phase_q == PH_CRASH) begin
							rd_q <= '0;
							rvalid_s1 <= 1'b0;
							for (int i = 0; i < AXES; i++) begin
								sum_q[i] <= '0;
							end
							state_q <= ST_SUM;
						end else begin
							// The release that leaves classification captures the offset.
							for (int i = 0; i < AXES; i++) begin
								off_q[i] <= $signed(s_tdata[16*i +: 16]);
							end
							phase_q <= PH_HIHAT;
							state_q <= ST_OUT;
						end
					end
				end
				ST_MAG, ST_SQ: begin
					if (step_q != 3'd0) begin
						acc_q <= acc_q + prod_q;
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						state_q <= (state_q == ST_MAG) ? ST_CMP : ST_NS;
					end
				end
				ST_CMP: begin
					step_q <= '0;
					if (!over_thr) begin
						state_q <= ST_OUT;
					end else if (phase_q == PH_HIHAT || phase_q == PH_CRASH) begin
						ptr_q[cls] <= (ptr_q[cls] == IW'(STORE_DEPTH - 1)) ? '0 :
							ptr_q[cls] + 1'b1;
						if (cnt_q[cls] < CW'(STORE_DEPTH)) begin
							cnt_q[cls] <= cnt_q[cls] + 1'b1;
						end
						gest_q <= cls ? GEST_CRASH : GEST_HIHAT;
						lvl_q <= cls ? 1'b1 : pedal_q;
						state_q <= ST_OUT;
					end else begin
						acc_q <= '0;
						dc_q <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					if (step_q >= 3'd1 && step_q <= 3'd3) begin
						acc_q <= acc_q + prod_q;
					end else if (step_q >= 3'd4) begin
						dc_q <= dc_q + prod_q;
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						step_q <= '0;
						state_q <= ST_WGT;
					end
				end
				ST_WGT: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) begin
						wh_q <= prod_q;
					end else if (step_q == 3'd2) begin
						// A tie goes to crash.
						if (wh_q > prod_q) begin
							gest_q <= GEST_HIHAT;
							lvl_q <= pedal_q;
						end else begin
							gest_q <= GEST_CRASH;
							lvl_q <= 1'b1;
						end
						state_q <= ST_OUT;
					end
				end
				ST_SUM: begin
					if (mem_re) begin
						rd_q <= rd_q + 1'b1;
					end
					rvalid_s1 <= mem_re;
					if (rvalid_s1) begin
						for (int i = 0; i < AXES; i++) begin
							sum_q[i] <= sum_q[i] + SW'($signed(mem_rdata[D_W*i +: D_W]));
						end
					end
					if (!mem_re && !rvalid_s1) begin
						comp_q <= '0;
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						cent_q[cbase + 3'(comp_q)] <= avg;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							acc_q <= '0;
							step_q <= '0;
							state_q <= ST_SQ;
						end else begin
							state_q <= ST_DIVS;
						end
					end
				end
				ST_NS: begin
					state_q <= ST_NW;
				end
				ST_NW: begin
					if (div_done) begin
						norm_q[cls] <= (div_q > DVW'(NORM_MAX)) ? NORM_MAX :
							div_q[NORM_W-1:0];
						cnt_q[cls] <= '0;
						ptr_q[cls] <= '0;
						phase_q <= cls ? PH_CLASSIFY : PH_CRASH;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_q <= {3'd0, phase_q, lvl_q, gest_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("phase register holds unused code");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(STORE_DEPTH) && cnt_q[1] <= CW'(STORE_DEPTH))
		else $error("class count above store depth");

	a_quiet_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == GEST_NONE |-> !m_tdata[2])
		else $error("level set without gesture");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> !mem_we) else $error("store written during centroid sweep");

	a_release_resets: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NW && div_done |=> cnt_q[$past(cls)] == '0)
		else $error("class count not cleared after centroid");
`endif

endmodule

>>> test/two_class_motion_gesture_classifier_tb.sv
`timescale 1ns / 1ps

module two_class_motion_gesture_classifier_tb;
	import gcls_pkg::*;

	localparam int DEPTH = 64;

	typedef struct {
		logic [1:0] gesture;
		logic       level;
		logic [1:0] mode;
	} gest_word_t;

	typedef struct {
		logic        op;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        pedal;
		bit          typed;
		gest_word_t  want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	two_class_motion_gesture_classifier dut (.*);

	// Shadow copy of the classifier state.
	logic [31:0] thr_q;
	logic [15:0] div_q;
	logic [1:0]  phase_q;
	int          offset_q[3];
	int          ring_q[2][DEPTH][3];
	int          count_q[2];
	int          wptr_q[2];
	int          cent_q[6];
	longint      norm_q[2];

	gest_word_t  pending_gestures[$];
	int          errors;
	int          words_in;
	int          words_out;
	int          strong_seen;
	int          send_pct;
	int          recv_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic close_class(input int cls);
		int n;
		longint s;
		longint sq;
		longint d;
		n = (count_q[cls] > DEPTH) ? DEPTH : count_q[cls];
		sq = 0;
		for (int c = 0; c < 3; c++) begin
			s = 0;
			for (int i = 0; i < n; i++) s += ring_q[cls][i][c];
			cent_q[cls*3+c] = (n != 0) ? int'(s / n) : 0;
			sq += longint'(cent_q[cls*3+c]) * cent_q[cls*3+c];
		end
		d = (div_q == 0) ? 1 : div_q;
		norm_q[cls] = sq / d;
		if (norm_q[cls] > NORM_MAX) norm_q[cls] = NORM_MAX;
		count_q[cls] = 0;
		wptr_q[cls] = 0;
	endtask

	task automatic classify_word(input logic op, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic pedal, output gest_word_t r);
		int a[3];
		int dd[3];
		longint mag;
		longint dh;
		longint dc;
		int p;
		a[0] = $signed(x);
		a[1] = $signed(y);
		a[2] = $signed(z);
		r.gesture = GEST_NONE;
		r.level = 1'b0;
		if (op) begin
			if (phase_q == PH_HIHAT) begin
				close_class(0);
				phase_q = PH_CRASH;
			end else if (phase_q == PH_CRASH) begin
				close_class(1);
				phase_q = PH_CLASSIFY;
			end else begin
				for (int c = 0; c < 3; c++) offset_q[c] = a[c];
				phase_q = PH_HIHAT;
			end
		end else begin
			mag = 0;
			for (int c = 0; c < 3; c++) begin
				mag += longint'(a[c]) * a[c];
				dd[c] = a[c] - offset_q[c];
			end
			if (mag > longint'(thr_q)) begin
				strong_seen++;
				if (phase_q == PH_HIHAT || phase_q == PH_CRASH) begin
					p = wptr_q[phase_q];
					for (int c = 0; c < 3; c++) ring_q[phase_q][p][c] = dd[c];
					wptr_q[phase_q] = (p + 1 >= DEPTH) ? 0 : p + 1;
					if (count_q[phase_q] < DEPTH) count_q[phase_q]++;
					r.gesture = (phase_q == PH_CRASH) ? GEST_CRASH : GEST_HIHAT;
					r.level = (phase_q == PH_CRASH) ? 1'b1 : pedal;
				end else begin
					dh = 0;
					dc = 0;
					for (int c = 0; c < 3; c++) begin
						dh += longint'(dd[c]) * cent_q[c];
						dc += longint'(dd[c]) * cent_q[3+c];
					end
					if (dh * norm_q[1] > dc * norm_q[0]) begin
						r.gesture = GEST_HIHAT;
						r.level = pedal;
					end else begin
						r.gesture = GEST_CRASH;
						r.level = 1'b1;
					end
				end
			end
		end
		r.mode = phase_q;
	endtask

	// Presents one word and holds it until the block takes it.
	task automatic send_word(input stim_row_t row);
		gest_word_t r;
		s_tvalid <= 1'b1;
		s_tuser <= row.op;
		s_tdata <= {7'd0, row.pedal, row.z, row.y, row.x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		classify_word(row.op, row.x, row.y, row.z, row.pedal, r);
		pending_gestures.push_back(row.typed ? row.want : r);
		words_in++;
		if ($urandom_range(0, 99) < send_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_gestures.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 3'(4 * REG_THRESHOLD)) thr_q = val;
		else div_q = val[15:0];
	endtask

	function automatic stim_row_t mk(input logic op, input int x, input int y, input int z,
			input logic pedal);
		stim_row_t row;
		row.op = op;
		row.x = 16'(x);
		row.y = 16'(y);
		row.z = 16'(z);
		row.pedal = pedal;
		row.typed = 0;
		row.want = '{GEST_NONE, 1'b0, PH_CLASSIFY};
		return row;
	endfunction

	function automatic stim_row_t mkx(input logic op, input int x, input int y, input int z,
			input logic pedal, input logic [1:0] g, input logic l, input logic [1:0] m);
		stim_row_t row;
		row = mk(op, x, y, z, pedal);
		row.typed = 1;
		row.want = '{g, l, m};
		return row;
	endfunction

	function automatic stim_row_t rand_sample(input logic op);
		stim_row_t row;
		if ($urandom_range(0, 9) < 2)
			row = mk(op, $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
				$urandom_range(0, 600) - 300, $urandom_range(0, 1));
		else
			row = mk(op, $urandom, $urandom, $urandom, $urandom_range(0, 1));
		return row;
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_pct);
	end

	always @(posedge clk) begin
		gest_word_t w;
		if (m_tvalid && m_tready) begin
			words_out++;
			if (pending_gestures.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				w = pending_gestures.pop_front();
				if (m_tdata[1:0] !== w.gesture)
					report_mismatch($sformatf("gesture %0d, want %0d", m_tdata[1:0], w.gesture));
				if (m_tdata[2] !== w.level)
					report_mismatch($sformatf("level %0d, want %0d", m_tdata[2], w.level));
				if (m_tdata[4:3] !== w.mode)
					report_mismatch($sformatf("mode %0d, want %0d", m_tdata[4:3], w.mode));
			end
		end
	end

	stim_row_t directed[$];
	logic [31:0] thr_set[5] = '{32'd3000000, 32'd0, 32'd3221225472, 32'd0, 32'd100000};
	logic [15:0] div_set[5] = '{16'd30000, 16'd1, 16'd65535, 16'd0, 16'd1000};
	int idle_pct[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{33, 33}};

	initial begin
		int len;
		int budget;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		strong_seen = 0;
		send_pct = 0;
		recv_pct = 0;
		thr_q = 32'd3000000;
		div_q = 16'd30000;
		phase_q = PH_CLASSIFY;
		for (int c = 0; c < 3; c++) offset_q[c] = 0;
		for (int k = 0; k < 2; k++) begin
			count_q[k] = 0;
			wptr_q[k] = 0;
			norm_q[k] = 0;
		end
		for (int c = 0; c < 6; c++) cent_q[c] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset both classes are empty, so every strong sample ties to crash.
		directed.push_back(mkx(0, 0, 0, 0, 1, GEST_NONE, 0, PH_CLASSIFY));
		directed.push_back(mkx(0, 32767, 32767, 32767, 0, GEST_CRASH, 1, PH_CLASSIFY));
		directed.push_back(mkx(0, -32768, -32768, -32768, 1, GEST_CRASH, 1, PH_CLASSIFY));
		directed.push_back(mkx(1, 100, -200, 300, 1, GEST_NONE, 0, PH_HIHAT));
		directed.push_back(mkx(0, 32767, 32767, 32767, 1, GEST_HIHAT, 1, PH_HIHAT));
		directed.push_back(mkx(0, -32768, -32768, -32768, 0, GEST_HIHAT, 0, PH_HIHAT));
		directed.push_back(mkx(0, 10, 10, 10, 1, GEST_NONE, 0, PH_HIHAT));
		directed.push_back(mk(0, 20000, -5000, 3000, 1));
		directed.push_back(mkx(1, 0, 0, 0, 0, GEST_NONE, 0, PH_CRASH));
		directed.push_back(mkx(1, 0, 0, 0, 0, GEST_NONE, 0, PH_CLASSIFY));
		directed.push_back(mk(0, 30000, 1000, -2000, 1));
		directed.push_back(mk(0, -30000, 1000, 2000, 0));
		directed.push_back(mkx(1, -32768, 32767, 0, 0, GEST_NONE, 0, PH_HIHAT));
		directed.push_back(mkx(1, 0, 0, 0, 0, GEST_NONE, 0, PH_CRASH));
		directed.push_back(mkx(0, 32767, -32768, 32767, 0, GEST_CRASH, 1, PH_CRASH));
		directed.push_back(mk(0, -20000, 20000, 5000, 0));
		directed.push_back(mkx(0, -32768, 32767, 0, 1, GEST_CRASH, 1, PH_CRASH));
		directed.push_back(mkx(1, 0, 0, 0, 1, GEST_NONE, 0, PH_CLASSIFY));
		directed.push_back(mk(0, 25000, -25000, 10000, 1));
		directed.push_back(mk(0, -25000, 25000, -10000, 1));
		directed.push_back(mk(0, 0, 0, 32767, 0));
		foreach (directed[i]) send_word(directed[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 3) begin
				thr_set[ph] = $urandom_range(0, 32'd200000000);
				div_set[ph] = $urandom_range(1, 65535);
			end
			write_reg(3'(4 * REG_THRESHOLD), thr_set[ph]);
			write_reg(3'(4 * REG_DIVISOR), div_set[ph]);
			send_pct = idle_pct[ph % 4][0];
			recv_pct = idle_pct[ph % 4][1];
			budget = words_in + 210;
			while (words_in < budget) begin
				// Mostly short training runs; now and then one long enough to wrap the ring.
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 80) : $urandom_range(0, 12);
				for (int i = 0; i < len; i++) send_word(rand_sample(0));
				if ($urandom_range(0, 19) == 0) drain();
				send_word(rand_sample(1));
			end
			drain();
		end

		$display("Sent %0d words (%0d strong samples), checked %0d result words,",
			words_in, strong_seen, words_out);
		$display("over five register settings and four handshake idling patterns.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
